>>> src/text_console_writer_macros.svh
// Assertion shorthands used by the console sequencer.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcw: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcw: next-cycle check failed");

`endif

>>> src/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	// Item kinds
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Control characters
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_RETURN    = 8'h0D;
	localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHAR_BLANK     = 8'h20;

	// Cell contents after reset
	localparam logic [15:0] RESET_CELL = 16'h0720;

	// Configuration registers
	localparam int         CFG_INDEX_W = 2;
	localparam int         COLOR_W     = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd1;
	localparam logic [COLOR_W-1:0]     FG_RESET       = 4'h7;
	localparam logic [COLOR_W-1:0]     BG_RESET       = 4'h0;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_code;
		logic [10:0] read_address;
	} item_t;

	typedef struct packed {
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [15:0] cell_data;
	} result_t;

endpackage

>>> src/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/tcw_seq.sv
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module tcw_seq #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	localparam int CELLS  = COLUMNS * ROWS,
	localparam int AW     = $clog2(CELLS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tcw_pkg::item_t    item,
	output logic              done,
	output tcw_pkg::result_t  result,
	input  logic [7:0]        attr,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [15:0]       ram_wdata,
	output logic [AW-1:0]     ram_raddr,
	input  logic [15:0]       ram_rdata
);

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int SPAN  = (ROWS - 1) * COLUMNS;

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CLEAR  = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_FLUSH  = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;

	localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0]    SPAN_END  = AW'(SPAN);
	localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

	logic [2:0]       state_q;
	logic [AW-1:0]    ptr_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             done_q;
	logic [15:0]      data_q;

	logic             wr_s1;
	logic [AW-1:0]    waddr_s1;
	logic             copy_s1;

	logic             accept;
	logic             is_put, is_clear, is_read;
	logic             addr_ok;
	logic             printable;
	logic [COL_W:0]   col_p1;
	logic [COL_W-1:0] col_d;
	logic [ROW_W-1:0] row_d;
	logic             row_inc;
	logic             scroll_go;
	logic [AW-1:0]    put_idx;
	logic [15:0]      blank;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign is_put    = (item.kind == tcw_pkg::KIND_PUT);
	assign is_clear  = (item.kind == tcw_pkg::KIND_CLEAR);
	assign is_read   = (item.kind == tcw_pkg::KIND_READ);
	assign addr_ok   = (32'(item.read_address) < CELLS);
	assign blank     = {attr, tcw_pkg::CHAR_BLANK};
	assign put_idx   = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign col_p1    = {1'b0, col_q} + 1'b1;
	assign printable = (item.char_code != tcw_pkg::CHAR_NEWLINE)
	                && (item.char_code != tcw_pkg::CHAR_RETURN)
	                && (item.char_code != tcw_pkg::CHAR_BACKSPACE);

	// Work out the cursor move of a put
	always_comb begin
		col_d   = col_q;
		row_inc = 1'b0;
		priority if (item.char_code == tcw_pkg::CHAR_NEWLINE) begin
			col_d   = '0;
			row_inc = 1'b1;
		end else if (item.char_code == tcw_pkg::CHAR_RETURN) begin
			col_d = '0;
		end else if (item.char_code == tcw_pkg::CHAR_BACKSPACE) begin
			if (col_q != '0) begin
				col_d = col_q - 1'b1;
			end
		end else if (col_p1 == (COL_W + 1)'(COLUMNS)) begin
			col_d   = '0;
			row_inc = 1'b1;
		end else begin
			col_d = col_p1[COL_W-1:0];
		end
		scroll_go = row_inc && (row_q == LAST_ROW);
		row_d     = (row_inc && !scroll_go) ? row_q + 1'b1 : row_q;
	end

	// Pick the single write of this cycle
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = blank;
		priority if (wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = copy_s1 ? ram_rdata : blank;
		end else if (state_q == ST_INIT) begin
			ram_we    = 1'b1;
			ram_wdata = tcw_pkg::RESET_CELL;
		end else if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (accept && is_put && printable) begin
			ram_we    = 1'b1;
			ram_waddr = put_idx;
			ram_wdata = {attr, item.char_code};
		end else begin
			ram_we = 1'b0;
		end
	end

	// Scroll reads one row ahead, otherwise serve the read item
	assign ram_raddr = (state_q == ST_SCROLL) ? ptr_q + AW'(COLUMNS)
	                                          : AW'(item.read_address);

	// Register the scroll write until its read data returns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= (state_q == ST_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= ptr_q;
		copy_s1  <= (ptr_q < SPAN_END);
	end

	// Sequence items and screen sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
			data_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						data_q <= '0;
						ptr_q  <= '0;
						priority if (is_put) begin
							col_q <= col_d;
							row_q <= row_d;
							if (scroll_go) begin
								state_q <= ST_SCROLL;
							end else begin
								done_q <= 1'b1;
							end
						end else if (is_clear) begin
							col_q   <= '0;
							row_q   <= '0;
							state_q <= ST_CLEAR;
						end else if (is_read && addr_ok) begin
							state_q <= ST_READ;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_SCROLL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_READ: begin
					data_q  <= ram_rdata;
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done                 = done_q;
	assign result.cursor_column = 7'(col_q);
	assign result.cursor_row    = 5'(row_q);
	assign result.cell_data     = data_q;

	`TCW_ASSERT_IMP(a_done_when_idle, clk, arst_n, done_q, state_q == ST_IDLE)
	`TCW_ASSERT_IMP(a_cursor_in_range, clk, arst_n, 1'b1,
		(32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
	`TCW_ASSERT_IMP(a_copy_write_in_scroll, clk, arst_n, wr_s1,
		(state_q == ST_SCROLL) || (state_q == ST_FLUSH))
	`TCW_ASSERT_NEXT(a_scroll_ends_in_flush, clk, arst_n,
		(state_q == ST_SCROLL) && (ptr_q == LAST_CELL), state_q == ST_FLUSH)

endmodule

>>> src/text_console_writer.sv
`timescale 1ns / 1ps

// Text console: COLUMNS x ROWS cells of {attribute, character} held in one
// single-port-write RAM, with a cursor. An item is taken when start is high
// and busy is low; its one result word appears on result for exactly one
// cycle with done high, and cannot be stalled, so the receiver must take it
// then. Timing is set by the single RAM write port, one cell per cycle: a
// put without scroll (control characters included) or an ignored kind
// shows its result in the cycle after acceptance; a read passes through the
// read state for the registered RAM read, or is answered like an ignored
// kind for an address off the screen; a clear sweeps every cell; a put that
// scrolls sweeps every cell, copying each row up and blanking the bottom
// row, then passes a flush state. After reset the block sweeps the whole RAM
// to 0x0720 with busy high; cfg writes are taken at any time, always ready.

module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tcw_pkg::item_t                      item,
	output logic                                done,
	output tcw_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]         cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [tcw_pkg::COLOR_W-1:0] fg_q;
	logic [tcw_pkg::COLOR_W-1:0] bg_q;
	logic [7:0]                  attr;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [15:0]                 ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [15:0]                 ram_rdata;

	assign cfg_ready = 1'b1;

	// Take colour words from the configuration channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::FG_RESET;
			bg_q <= tcw_pkg::BG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tcw_pkg::REG_FOREGROUND) begin
				fg_q <= cfg_data;
			end
			if (cfg_index == tcw_pkg::REG_BACKGROUND) begin
				bg_q <= cfg_data;
			end
		end
	end

	assign attr = {bg_q, fg_q};

	tcw_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.attr      (attr),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
